// ===== hdl/jsu_pkg.sv =====
`timescale 1ns / 1ps

package jsu_pkg;

   // Result kinds (rsp_tuser)
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Error codes
   localparam logic [3:0] ERR_NONE          = 4'd0;
   localparam logic [3:0] ERR_NO_QUOTE      = 4'd1;
   localparam logic [3:0] ERR_UNTERMINATED  = 4'd2;
   localparam logic [3:0] ERR_TRUNC_ESCAPE  = 4'd3;
   localparam logic [3:0] ERR_BAD_ESCAPE    = 4'd4;
   localparam logic [3:0] ERR_TRUNC_UNICODE = 4'd5;
   localparam logic [3:0] ERR_BAD_HEX       = 4'd6;
   localparam logic [3:0] ERR_BAD_LOW       = 4'd7;
   localparam logic [3:0] ERR_UNPAIRED_HIGH = 4'd8;

   // Queue between decoder and serializer
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   // Results caused by one input transaction: up to four bytes,
   // bytes[0] goes out first, last_idx is the index of the final one.
   typedef struct packed {
      logic [1:0]      last_idx;
      logic [1:0]      kind;
      logic [3:0]      err;
      logic [3:0][7:0] bytes;
   } bundle_type;

endpackage

// ===== hdl/jsu_front.sv =====
`timescale 1ns / 1ps

// Decoder: accepts one text byte per cycle while the queue is not full, tracks the string
// phase and turns each transaction that yields results into a bundle for the queue.
module jsu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tuser,
   input  logic                q_full,
   output logic                push,
   output jsu_pkg::bundle_type push_data
);

   typedef enum logic [6:0] {
      PH_IDLE   = 7'b0000001,
      PH_STR    = 7'b0000010,
      PH_ESC    = 7'b0000100,
      PH_HEX1   = 7'b0001000,
      PH_WANTBS = 7'b0010000,
      PH_WANTU  = 7'b0100000,
      PH_HEX2   = 7'b1000000
   } phase_type;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   phase_type   phase_ff, phase_in;
   logic [15:0] hex_accum_ff, hex_accum_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [9:0]  high_part_ff, high_part_in;

   logic                accept;
   logic                has_result;
   jsu_pkg::bundle_type bnd;
   logic [4:0]          hex_dec;
   logic [15:0]         hex_next;
   logic                hex_done;
   logic [20:0]         cp_pair;

   // ---- result builders ----
   function automatic jsu_pkg::bundle_type mk_single(input logic [7:0] b,
                                                     input logic [1:0] k,
                                                     input logic [3:0] e);
      jsu_pkg::bundle_type r;
      r          = '0;
      r.last_idx = 2'd0;
      r.kind     = k;
      r.err      = e;
      r.bytes[0] = b;
      return r;
   endfunction

   function automatic jsu_pkg::bundle_type enc16(input logic [15:0] cp);
      jsu_pkg::bundle_type r;
      r      = '0;
      r.kind = jsu_pkg::KIND_DATA;
      r.err  = jsu_pkg::ERR_NONE;
      if (cp < 16'h0080) begin
         r.last_idx = 2'd0;
         r.bytes[0] = cp[7:0];
      end else if (cp < 16'h0800) begin
         r.last_idx = 2'd1;
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
      end else begin
         r.last_idx = 2'd2;
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

   function automatic jsu_pkg::bundle_type enc21(input logic [20:0] cp);
      jsu_pkg::bundle_type r;
      r          = '0;
      r.kind     = jsu_pkg::KIND_DATA;
      r.err      = jsu_pkg::ERR_NONE;
      r.last_idx = 2'd3;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      return r;
   endfunction

   // {valid, nibble}
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]})      r = {1'b1, c[3:0]};
      else if (c inside {[8'h61:8'h66]}) r = {1'b1, c[3:0] + 4'd9};
      else if (c inside {[8'h41:8'h46]}) r = {1'b1, c[3:0] + 4'd9};
      return r;
   endfunction

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // hex digit path shared by both \u fields
   assign hex_dec  = hex_val(req_tdata);
   assign hex_next = {hex_accum_ff[11:0], hex_dec[3:0]};
   assign hex_done = (hex_count_ff == 2'd3);
   assign cp_pair  = 21'h10000 + {1'b0, high_part_ff, hex_next[9:0]};

   // ---- next state and results ----
   always_comb begin
      phase_in     = phase_ff;
      hex_accum_in = hex_accum_ff;
      hex_count_in = hex_count_ff;
      high_part_in = high_part_ff;
      has_result   = 1'b0;
      bnd          = '0;

      if (req_tuser) begin
         // end of text
         has_result = 1'b1;
         phase_in   = PH_IDLE;
         case (phase_ff)
            PH_STR: bnd = mk_single(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERMINATED);
            PH_ESC: bnd = mk_single(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_TRUNC_ESCAPE);
            PH_HEX1, PH_HEX2:
               bnd = mk_single(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_TRUNC_UNICODE);
            PH_WANTBS, PH_WANTU:
               bnd = mk_single(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNPAIRED_HIGH);
            default: has_result = 1'b0;
         endcase
      end else begin
         case (phase_ff)
            PH_STR: begin
               if (req_tdata == CH_QUOTE) begin
                  has_result = 1'b1;
                  bnd        = mk_single(8'h00, jsu_pkg::KIND_END, jsu_pkg::ERR_NONE);
                  phase_in   = PH_IDLE;
               end else if (req_tdata == CH_BSLASH) begin
                  phase_in = PH_ESC;
               end else begin
                  has_result = 1'b1;
                  bnd        = mk_single(req_tdata, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
               end
            end
            PH_ESC: begin
               has_result = 1'b1;
               phase_in   = PH_STR;
               case (req_tdata)
                  CH_QUOTE, CH_BSLASH, CH_SLASH:
                     bnd = mk_single(req_tdata, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                  CH_B: bnd = mk_single(8'h08, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                  CH_F: bnd = mk_single(8'h0C, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                  CH_N: bnd = mk_single(8'h0A, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                  CH_R: bnd = mk_single(8'h0D, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                  CH_T: bnd = mk_single(8'h09, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                  CH_U: begin
                     has_result   = 1'b0;
                     phase_in     = PH_HEX1;
                     hex_accum_in = 16'h0000;
                     hex_count_in = 2'd0;
                  end
                  default: begin
                     bnd      = mk_single(8'h00, jsu_pkg::KIND_ERROR,
                                          jsu_pkg::ERR_BAD_ESCAPE);
                     phase_in = PH_IDLE;
                  end
               endcase
            end
            PH_HEX1, PH_HEX2: begin
               if (!hex_dec[4]) begin
                  has_result = 1'b1;
                  bnd        = mk_single(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_HEX);
                  phase_in   = PH_IDLE;
               end else begin
                  hex_accum_in = hex_next;
                  hex_count_in = hex_count_ff + 2'd1;
                  if (hex_done) begin
                     if (phase_ff == PH_HEX1) begin
                        if (hex_next[15:10] == 6'b110110) begin
                           // high surrogate: keep offset, await the low half
                           high_part_in = hex_next[9:0];
                           phase_in     = PH_WANTBS;
                        end else begin
                           has_result = 1'b1;
                           bnd        = enc16(hex_next);
                           phase_in   = PH_STR;
                        end
                     end else begin
                        has_result = 1'b1;
                        if (hex_next[15:10] == 6'b110111) begin
                           bnd      = enc21(cp_pair);
                           phase_in = PH_STR;
                        end else begin
                           bnd      = mk_single(8'h00, jsu_pkg::KIND_ERROR,
                                                jsu_pkg::ERR_BAD_LOW);
                           phase_in = PH_IDLE;
                        end
                     end
                  end
               end
            end
            PH_WANTBS: begin
               if (req_tdata == CH_BSLASH) begin
                  phase_in = PH_WANTU;
               end else begin
                  has_result = 1'b1;
                  bnd        = mk_single(8'h00, jsu_pkg::KIND_ERROR,
                                         jsu_pkg::ERR_UNPAIRED_HIGH);
                  phase_in   = PH_IDLE;
               end
            end
            PH_WANTU: begin
               if (req_tdata == CH_U) begin
                  phase_in     = PH_HEX2;
                  hex_accum_in = 16'h0000;
                  hex_count_in = 2'd0;
               end else begin
                  has_result = 1'b1;
                  bnd        = mk_single(8'h00, jsu_pkg::KIND_ERROR,
                                         jsu_pkg::ERR_UNPAIRED_HIGH);
                  phase_in   = PH_IDLE;
               end
            end
            default: begin
               // idle: wait for the opening quote
               if (req_tdata == CH_QUOTE) begin
                  phase_in = PH_STR;
               end else begin
                  has_result = 1'b1;
                  bnd        = mk_single(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_NO_QUOTE);
                  phase_in   = PH_IDLE;
               end
            end
         endcase
      end
   end

   assign push      = accept && has_result;
   assign push_data = bnd;

   // ---- state registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         hex_accum_ff <= 16'h0000;
         hex_count_ff <= 2'd0;
         high_part_ff <= 10'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         hex_accum_ff <= hex_accum_in;
         hex_count_ff <= hex_count_in;
         high_part_ff <= high_part_in;
      end
   end

endmodule

// ===== hdl/jsu_queue.sv =====
`timescale 1ns / 1ps

// Small FIFO of result bundles between decoder and serializer.
module jsu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jsu_pkg::bundle_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                q_valid,
   output jsu_pkg::bundle_type q_data
);

   jsu_pkg::bundle_type entry_ff [jsu_pkg::Q_DEPTH];

   logic [jsu_pkg::Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [jsu_pkg::Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [jsu_pkg::Q_AW:0]   count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign full    = (count_ff == (jsu_pkg::Q_AW+1)'(jsu_pkg::Q_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_data  = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + (jsu_pkg::Q_AW)'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + (jsu_pkg::Q_AW)'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop)      count_in = count_ff + (jsu_pkg::Q_AW+1)'(1);
      else if (do_pop && !do_push) count_in = count_ff - (jsu_pkg::Q_AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== hdl/jsu_back.sv =====
`timescale 1ns / 1ps

// Serializer: walks one bundle a byte per cycle into the output register while rsp_tready allows.
module jsu_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  jsu_pkg::bundle_type q_data,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser,
   output logic                rsp_tlast
);

   jsu_pkg::bundle_type wk_ff, wk_in;
   logic                wk_valid_ff, wk_valid_in;
   logic [1:0]          idx_ff, idx_in;

   logic                out_valid_ff, out_valid_in;
   logic [7:0]          out_byte_ff, out_byte_in;
   logic [1:0]          out_kind_ff, out_kind_in;
   logic [3:0]          out_err_ff, out_err_in;
   logic                out_last_ff, out_last_in;

   logic                adv;
   logic                wk_done;

   // move one result when the output slot is free or being drained
   assign adv     = wk_valid_ff && (!out_valid_ff || rsp_tready);
   assign wk_done = adv && (idx_ff == wk_ff.last_idx);
   assign pop     = q_valid && (!wk_valid_ff || wk_done);

   // working bundle
   always_comb begin
      wk_in       = wk_ff;
      wk_valid_in = wk_valid_ff;
      idx_in      = idx_ff;
      if (pop) begin
         wk_in       = q_data;
         wk_valid_in = 1'b1;
         idx_in      = 2'd0;
      end else if (wk_done) begin
         wk_valid_in = 1'b0;
      end else if (adv) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_kind_in  = out_kind_ff;
      out_err_in   = out_err_ff;
      out_last_in  = out_last_ff;
      if (adv) begin
         out_valid_in = 1'b1;
         out_byte_in  = wk_ff.bytes[idx_ff];
         out_kind_in  = wk_ff.kind;
         out_err_in   = wk_ff.err;
         out_last_in  = (idx_ff == wk_ff.last_idx);
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wk_valid_ff  <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         wk_valid_ff  <= wk_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wk_ff       <= wk_in;
      out_byte_ff <= out_byte_in;
      out_kind_ff <= out_kind_in;
      out_err_ff  <= out_err_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'h0, out_err_ff, out_byte_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== hdl/json_string_unescape_utf8_unit.sv =====
`timescale 1ns / 1ps

// JSON string literal decoder, text bytes in, UTF-8 bytes out.
// Input channel req_*: one text byte per transaction, starting at the opening
// quote; req_tuser set marks end of text (req_tdata then ignored).
// Result channel rsp_*: decoded bytes, an end marker at the closing quote, or
// one error result (rsp_tdata[11:8] = code) after which decoding restarts at idle.
// rsp_tlast flags the final result caused by one input transaction.
// A result passes the bundle queue, the working bundle and the output register.
// Throughput: one input per cycle while the four-entry bundle queue has room;
// the serializer emits one result per cycle while rsp_tready is high, so a
// surrogate pair that yields four UTF-8 bytes sends them as four results.
// Reset (synchronous, active high) returns to idle and empties queue and output.
// When rsp_tready is low the output register holds its result; the queue
// then fills and req_tready drops once all four entries are taken.
module json_string_unescape_utf8_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tuser,   // [0] end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [11:8] error_code, [15:12] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);

   logic                push;
   jsu_pkg::bundle_type push_data;
   logic                q_full;
   logic                pop;
   logic                q_valid;
   jsu_pkg::bundle_type q_data;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_data  (push_data)
   );

   jsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .q_valid   (q_valid),
      .q_data    (q_data)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a non-error result never carries an error code
   a_err_code_only_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != jsu_pkg::KIND_ERROR) |-> (rsp_tdata[11:8] == 4'd0))
      else $error("error code set on non-error result");

   // end and error results are always the final result of their transaction
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != jsu_pkg::KIND_DATA) |-> rsp_tlast)
      else $error("end or error result without last");

   // decoder never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("push into full queue");

   // a bundle is taken only when one is present
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("pop from empty queue");

endmodule
